// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator package
// Codes, field widths and the command and status bundles shared by the
// controller, the datapath and the checker.
// ----------------------------------------------------------------------------
package bsa_pkg;

	// Operation codes carried in the input beat's tuser.
	localparam logic [1:0] OP_CLAIM     = 2'd0;
	localparam logic [1:0] OP_RELEASE   = 2'd1;
	localparam logic [1:0] OP_TEST_ADDR = 2'd2;
	localparam logic [1:0] OP_TEST_SLOT = 2'd3;

	// Result status codes carried in the output beat's tuser.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVAL   = 2'd1;
	localparam logic [1:0] ST_CORRUPT = 2'd2;
	localparam logic [1:0] ST_UNAVAIL = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_BASE   = 2'd0;
	localparam logic [1:0] CFG_OSIZE  = 2'd1;
	localparam logic [1:0] CFG_SCOUNT = 2'd2;

	// Field widths.
	localparam int ADDR_W   = 32;
	localparam int OSIZE_W  = 16;
	localparam int SCOUNT_W = 9;
	localparam int SIDX_W   = 16;
	localparam int SLOT_W   = 8;
	localparam int COUNT_W  = 9;
	localparam int WORD_W   = 32;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 64;

	// Register values after reset.
	localparam logic [OSIZE_W-1:0]  RST_OSIZE  = 16'd16;
	localparam logic [SCOUNT_W-1:0] RST_SCOUNT = 9'd256;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ready;
		logic scan_init;
		logic scan_step;
		logic rd_slot;
		logic mul;
		logic div_start;
		logic div_check;
		logic latch;
		logic result_en;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       accept;
		logic       bad_shape;
		logic [1:0] op;
		logic       found;
		logic       exhausted;
		logic       div_done;
		logic       out_free;
	} stat_t;

endpackage

// ===== rtl/core/bsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/core/bsa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsa_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bsa_pkg::ADDR_W-1:0]   dividend,
	input  logic [bsa_pkg::OSIZE_W-1:0]  divisor,
	output logic                         done,
	output logic [bsa_pkg::ADDR_W-1:0]   quotient,
	output logic [bsa_pkg::OSIZE_W-1:0]  remainder
);

	logic                          busy_q;
	logic                          done_q;
	logic [4:0]                    cnt_q;
	logic [bsa_pkg::ADDR_W-1:0]    quo_q;
	logic [bsa_pkg::OSIZE_W-1:0]   rem_q;
	logic [bsa_pkg::OSIZE_W-1:0]   dvs_q;
	logic [bsa_pkg::OSIZE_W:0]     trial;
	logic                          fits;

	// Shift in the next dividend bit and try a subtract.
	assign trial = {rem_q, quo_q[bsa_pkg::ADDR_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Sequencing flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Partial remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= bsa_pkg::OSIZE_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[bsa_pkg::OSIZE_W-1:0];
			end
			quo_q <= {quo_q[bsa_pkg::ADDR_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/bsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator controller
// Sequences one operation at a time through the datapath.
// ----------------------------------------------------------------------------
module bsa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  bsa_pkg::stat_t  stat,
	output bsa_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_EV,
		S_MUL,
		S_DIV,
		S_TEST_RD,
		S_TEST_EV,
		S_RESULT,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands for the current state.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (stat.accept) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.bad_shape) begin
					state_d = S_RESULT;
				end else begin
					unique case (stat.op)
						bsa_pkg::OP_CLAIM: begin
							cmd.scan_init = 1'b1;
							state_d       = S_SCAN_RD;
						end
						bsa_pkg::OP_RELEASE, bsa_pkg::OP_TEST_ADDR: begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
						default: begin
							state_d = S_TEST_RD;
						end
					endcase
				end
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd.scan_step = 1'b1;
				if (stat.found) begin
					state_d = S_MUL;
				end else if (stat.exhausted) begin
					state_d = S_RESULT;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_RESULT;
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.div_check = 1'b1;
					state_d       = S_TEST_RD;
				end
			end
			S_TEST_RD: begin
				cmd.rd_slot = 1'b1;
				state_d     = S_TEST_EV;
			end
			S_TEST_EV: begin
				cmd.latch = 1'b1;
				state_d   = S_RESULT;
			end
			S_RESULT: begin
				cmd.result_en = 1'b1;
				state_d       = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/bsa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Configuration, claim bitmap, search window, divider, counters and the
// output register.
// ----------------------------------------------------------------------------
module bsa_datapath #(
	parameter int MAX_SLOTS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [bsa_pkg::ADDR_W-1:0]      cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bsa_pkg::IN_W-1:0]        s_tdata,
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bsa_pkg::OUT_W-1:0]       m_tdata,
	output logic [1:0]                      m_tuser,
	input  bsa_pkg::cmd_t                   cmd,
	output bsa_pkg::stat_t                  stat
);

	localparam int SW        = $clog2(MAX_SLOTS);
	localparam int CW        = SW + 1;
	localparam int MAP_WORDS = (MAX_SLOTS + 31) / 32;
	localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	// Configuration registers.
	logic [bsa_pkg::ADDR_W-1:0]   base_q;
	logic [bsa_pkg::OSIZE_W-1:0]  osize_q;
	logic [bsa_pkg::SCOUNT_W-1:0] scount_q;

	// Captured input beat.
	logic [1:0]                   op_q;
	logic [bsa_pkg::ADDR_W-1:0]   addr_q;
	logic [bsa_pkg::SIDX_W-1:0]   sidx_q;

	// Allocator state.
	logic [SW-1:0]                ss_q;
	logic [bsa_pkg::COUNT_W-1:0]  live_q;
	logic [bsa_pkg::COUNT_W-1:0]  peak_q;
	logic [MAP_WORDS-1:0]         wvalid_q;

	// Working registers.
	logic [SW-1:0]                start_q;
	logic [WW-1:0]                word_q;
	logic                         pass_q;
	logic                         found_q;
	logic [SW-1:0]                slot_q;
	logic [bsa_pkg::WORD_W-1:0]   data_q;
	logic                         below_q;
	logic                         cont_q;
	logic [SW+15:0]               prod_s1;
	logic [WW-1:0]                rd_word_s1;

	// Result and output registers.
	logic [1:0]                   r_status_q;
	logic [bsa_pkg::OUT_W-1:0]    r_data_q;
	logic                         m_tvalid_q;
	logic [1:0]                   m_tuser_q;
	logic [bsa_pkg::OUT_W-1:0]    m_tdata_q;

	logic                         accept;
	logic                         bad_shape;
	logic [CW-1:0]                cap;
	logic [SW-1:0]                start_c;
	logic [WW-1:0]                rd_word;
	logic [WW-1:0]                slot_word;
	logic [bsa_pkg::WORD_W-1:0]   ram_rd;
	logic [bsa_pkg::WORD_W-1:0]   rd_eff;
	logic [bsa_pkg::WORD_W-1:0]   win_mask;
	logic [bsa_pkg::WORD_W-1:0]   free_v;
	logic [4:0]                   free_bit;
	logic                         any_free;
	logic [WW-1:0]                last_word;
	logic [WW-1:0]                start_word;
	logic                         div_done;
	logic [bsa_pkg::ADDR_W-1:0]   quo;
	logic [bsa_pkg::OSIZE_W-1:0]  rem;
	logic                         slot_bit;
	logic                         in_range;

	logic                         wr_en;
	logic [bsa_pkg::WORD_W-1:0]   wr_data;
	logic [1:0]                   res_status;
	logic [bsa_pkg::ADDR_W-1:0]   res_oaddr;
	logic [bsa_pkg::SLOT_W-1:0]   res_slot;
	logic                         res_cont;
	logic                         res_clm;
	logic [bsa_pkg::COUNT_W-1:0]  live_d;
	logic [bsa_pkg::COUNT_W-1:0]  peak_d;
	logic [SW-1:0]                ss_d;

	assign accept    = s_tvalid && cmd.ready;
	assign s_tready  = cmd.ready;
	assign bad_shape = (osize_q == '0) || (scount_q == '0);

	// Slots in use, limited to the built size.
	always_comb begin
		if (32'(scount_q) > 32'(MAX_SLOTS)) begin
			cap = CW'(MAX_SLOTS);
		end else begin
			cap = CW'(scount_q);
		end
	end

	// A hint left past the end by a register change restarts at slot zero.
	assign start_c = (32'(ss_q) < 32'(cap)) ? ss_q : '0;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			osize_q  <= bsa_pkg::RST_OSIZE;
			scount_q <= bsa_pkg::RST_SCOUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsa_pkg::CFG_BASE:   base_q   <= cfg_data;
				bsa_pkg::CFG_OSIZE:  osize_q  <= cfg_data[bsa_pkg::OSIZE_W-1:0];
				bsa_pkg::CFG_SCOUNT: scount_q <= cfg_data[bsa_pkg::SCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Bitmap storage. Words never written read as all free.
	assign slot_word = WW'(32'(slot_q) >> 5);
	assign rd_word   = cmd.rd_slot ? slot_word : word_q;

	bsa_ram #(
		.WIDTH (bsa_pkg::WORD_W),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot_word),
		.wr_data (wr_data),
		.rd_addr (rd_word),
		.rd_data (ram_rd)
	);

	assign rd_eff = wvalid_q[rd_word_s1] ? ram_rd : '0;

	// Search window over the word in hand: from the hint to the end on the
	// first pass, from slot zero up to the hint on the wrapped pass.
	always_comb begin
		for (int j = 0; j < bsa_pkg::WORD_W; j++) begin
			if (pass_q) begin
				win_mask[j] = ((32'(word_q) << 5) | 32'(j)) < 32'(start_q);
			end else begin
				win_mask[j] = (((32'(word_q) << 5) | 32'(j)) >= 32'(start_q)) &&
					(((32'(word_q) << 5) | 32'(j)) < 32'(cap));
			end
		end
	end

	assign free_v   = ~rd_eff & win_mask;
	assign any_free = |free_v;

	// Lowest free slot in the window.
	always_comb begin
		free_bit = '0;
		for (int j = bsa_pkg::WORD_W - 1; j >= 0; j--) begin
			if (free_v[j]) begin
				free_bit = 5'(j);
			end
		end
	end

	assign last_word  = WW'((32'(cap) - 32'd1) >> 5);
	assign start_word = WW'(32'(start_q) >> 5);

	// Address to slot division.
	bsa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (addr_q - base_q),
		.divisor   (osize_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign slot_bit = data_q[slot_q[4:0]];
	assign in_range = 32'(sidx_q) < 32'(cap);

	// Result of the operation and the state it leaves behind.
	always_comb begin
		wr_en      = 1'b0;
		wr_data    = data_q;
		res_status = bsa_pkg::ST_OK;
		res_oaddr  = '0;
		res_slot   = '0;
		res_cont   = 1'b0;
		res_clm    = 1'b0;
		live_d     = live_q;
		peak_d     = peak_q;
		ss_d       = ss_q;
		if (bad_shape) begin
			res_status = bsa_pkg::ST_INVAL;
		end else begin
			case (op_q)
				bsa_pkg::OP_CLAIM: begin
					if (found_q) begin
						wr_en     = 1'b1;
						wr_data   = data_q | (32'd1 << slot_q[4:0]);
						live_d    = live_q + 9'd1;
						peak_d    = (live_d > peak_q) ? live_d : peak_q;
						ss_d      = ((32'(slot_q) + 32'd1) == 32'(cap)) ? '0 : slot_q + 1'b1;
						res_oaddr = base_q + 32'(prod_s1);
						res_slot  = 8'(slot_q);
						res_clm   = 1'b1;
					end else begin
						res_status = bsa_pkg::ST_UNAVAIL;
					end
				end
				bsa_pkg::OP_RELEASE: begin
					if (!cont_q) begin
						res_status = bsa_pkg::ST_INVAL;
					end else begin
						res_cont = 1'b1;
						res_slot = 8'(slot_q);
						if ((live_q == '0) || !slot_bit) begin
							res_status = bsa_pkg::ST_CORRUPT;
							res_clm    = slot_bit;
						end else begin
							wr_en   = 1'b1;
							wr_data = data_q & ~(32'd1 << slot_q[4:0]);
							live_d  = live_q - 9'd1;
							if (slot_q < ss_q) begin
								ss_d = slot_q;
							end
						end
					end
				end
				bsa_pkg::OP_TEST_ADDR: begin
					if (cont_q) begin
						res_cont = 1'b1;
						res_slot = 8'(slot_q);
						res_clm  = slot_bit;
					end
				end
				default: begin
					res_slot = sidx_q[bsa_pkg::SLOT_W-1:0];
					res_clm  = in_range && slot_bit;
				end
			endcase
		end
		wr_en = wr_en && cmd.result_en;
	end

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss_q       <= '0;
			live_q     <= '0;
			peak_q     <= '0;
			wvalid_q   <= '0;
			pass_q     <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.scan_init) begin
				pass_q  <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (any_free) begin
					found_q <= 1'b1;
				end else if (!pass_q && (word_q == last_word)) begin
					pass_q <= 1'b1;
				end
			end
			if (cmd.result_en) begin
				ss_q   <= ss_d;
				live_q <= live_d;
				peak_q <= peak_d;
			end
			if (wr_en) begin
				wvalid_q[slot_word] <= 1'b1;
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		rd_word_s1 <= rd_word;
		if (accept) begin
			op_q   <= s_tuser;
			addr_q <= s_tdata[bsa_pkg::ADDR_W-1:0];
			sidx_q <= s_tdata[bsa_pkg::IN_W-1:bsa_pkg::ADDR_W];
			slot_q <= SW'(s_tdata[bsa_pkg::IN_W-1:bsa_pkg::ADDR_W]);
		end
		if (cmd.scan_init) begin
			start_q <= start_c;
			word_q  <= WW'(32'(start_c) >> 5);
		end else if (cmd.scan_step) begin
			data_q <= rd_eff;
			if (any_free) begin
				slot_q <= SW'((32'(word_q) << 5) | 32'(free_bit));
			end else if (!pass_q && (word_q == last_word)) begin
				word_q <= '0;
			end else begin
				word_q <= word_q + 1'b1;
			end
		end
		if (cmd.latch) begin
			data_q <= rd_eff;
		end
		if (cmd.mul) begin
			prod_s1 <= slot_q * osize_q;
		end
		if (cmd.div_start) begin
			below_q <= addr_q < base_q;
		end
		if (cmd.div_check) begin
			cont_q <= !below_q && (rem == '0) && (quo < 32'(cap));
			slot_q <= SW'(quo);
		end
		if (cmd.result_en) begin
			r_status_q <= res_status;
			r_data_q   <= {4'd0, peak_d, live_d, res_clm, res_cont, res_slot, res_oaddr};
		end
		if (cmd.load_out) begin
			m_tuser_q <= r_status_q;
			m_tdata_q <= r_data_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat           = '0;
		stat.accept    = accept;
		stat.bad_shape = bad_shape;
		stat.op        = op_q;
		stat.found     = any_free;
		stat.exhausted = pass_q && (word_q == start_word) && !any_free;
		stat.div_done  = div_done;
		stat.out_free  = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/core/bitmap_slot_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator core
// Next-fit allocator of fixed-size object slots over a claim bitmap, with
// release by address and claimed-state queries.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_*       in         tuser: op; tdata: address, slot_index
//  m_*       out        tuser: status; tdata: object_address, slot, contained,
//                       claimed, live_count, peak_count
//  cfg_*     in         register write: base_address, slot bytes, slot_count
//
// One operation is in flight at a time. A claim scans the bitmap memory a
// word at a time, visiting up to MAX_SLOTS/32 (rounded up) + 1 words. Release
// and address test wait on the divider; a slot test reads the slot's bitmap
// word directly. Reset clears the bitmap through per-word valid bits, so no
// clearing pass. A stalled result sits in the output register while the next
// beat is taken.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_core #(
	parameter int MAX_SLOTS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // address[31:0], slot_index[47:32]
	input  logic [1:0]   s_tuser,   // op[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // object_address[31:0], slot[39:32],
	                                // contained[40], claimed[41],
	                                // live_count[50:42], peak_count[59:51], zero
	output logic [1:0]   m_tuser    // status[1:0]
);

	bsa_pkg::cmd_t  cmd;
	bsa_pkg::stat_t stat;

	bsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	bsa_datapath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== rtl/core/bsa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator checker
// Port-level checks on the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsa_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic [1:0]   m_tuser
);

	// A stalled result beat holds.
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	// Only a successful claim reports an object address.
	`ASSERT_IMPL(a_addr_only_ok, m_tvalid && (m_tuser != bsa_pkg::ST_OK), m_tdata[31:0] == 32'd0, "address on a failed operation")

	// The live count never exceeds the high-water mark.
	`ASSERT_IMPL(a_live_le_peak, m_tvalid, m_tdata[50:42] <= m_tdata[59:51], "live count above peak")

	// An accepted beat keeps the input closed for at least the next cycle.
	`ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second beat taken while busy")

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
